### rtl/tts_pkg.sv
// Shared types and constants for the tick task scheduler table.
// No dependencies; imported by every module of the block.
package tts_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int RUN_W = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  localparam logic [2:0] KIND_ADDED   = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_INVALID = 3'd2;
  localparam logic [2:0] KIND_DELETED = 3'd3;
  localparam logic [2:0] KIND_RUN     = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] task_id;
    logic [31:0] first_delay;
    logic [31:0] repeat_period;
    logic [2:0]  slot_number;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [2:0]  slot_index;
    logic [15:0] run_task_id;
    logic [3:0]  active_count;
    logic        last_result;
  } rsp_t;

  typedef struct packed {
    logic [15:0] task_id;
    logic [31:0] countdown;
    logic [31:0] period;
  } slot_t;

  // outcome of handling the slot at the head of the ring
  typedef struct packed {
    slot_t       slot_new;
    logic        placed;
    logic        freed;
    logic        run;
    logic [15:0] old_id;
  } step_t;

endpackage

### rtl/tick_task_scheduler_table_unit.sv
// Top level of the tick task scheduler table: slot ring, head update and result register.
// Depends on tts_pkg, tts_cell and tts_step.
//
//  channel | signals                  | moves
//  --------+--------------------------+---------------------------------------
//  request | req_valid, req_ready, req | add, delete or tick (tts_pkg::req_t)
//  result  | rsp_valid, rsp_ready, rsp | 0 to MAX_RESULTS results per request (tts_pkg::rsp_t)
//
// A request is taken while the block is idle, then turns the slot ring once, moving
// one slot through the head update per cycle while the result register is free.
// No new request is taken until the ring walk is through.
// A step that has a result to give waits until the result register is free.
// req_ready is high whenever no ring walk is in progress.
// Synchronous reset empties every slot and clears the count.
module tick_task_scheduler_table_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  tts_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output tts_pkg::rsp_t  rsp
);
  import tts_pkg::*;

  typedef enum logic {IDLE, WALK} state_t;

  state_t              state;
  req_t                cur;
  logic [IDX_W-1:0]    step_idx;
  logic                placed;
  logic [2:0]          placed_idx;
  logic [15:0]         old_id;
  logic [RUN_W-1:0]    run_n;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  logic                out_valid;
  rsp_t                out_q;

  slot_t               cell_q   [SLOT_COUNT];
  slot_t               cell_d   [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] cell_due;

  step_t               res;
  logic                out_free;
  logic                advance;
  logic                last_step;
  logic                index_match;
  logic                due_later;
  logic                emit;
  rsp_t                emit_rsp;

  assign out_free  = !out_valid || rsp_ready;
  assign advance   = (state == WALK) && out_free;
  assign last_step = (step_idx == IDX_W'(SLOT_COUNT - 1));
  assign index_match = (32'(cur.slot_number) < SLOT_COUNT) &&
                       (32'(step_idx) == 32'(cur.slot_number));

  for (genvar p = 0; p < SLOT_COUNT; p++) begin : g_ring
    if (p == SLOT_COUNT - 1) begin : g_tail
      assign cell_d[p] = res.slot_new;
    end else begin : g_mid
      assign cell_d[p] = cell_q[p+1];
    end
    tts_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (advance),
      .d     (cell_d[p]),
      .q     (cell_q[p]),
      .due   (cell_due[p])
    );
  end

  tts_step u_step (
    .req           (cur),
    .head          (cell_q[0]),
    .placed_before (placed),
    .index_match   (index_match),
    .res           (res)
  );

  // any unvisited slot behind the head that will run on this tick
  always_comb begin
    due_later = 1'b0;
    for (int p = 1; p < SLOT_COUNT; p++) begin
      if (cell_due[p] && (p + int'(step_idx) < SLOT_COUNT)) begin
        due_later = 1'b1;
      end
    end
  end

  assign count_next = count + CNT_W'(res.placed) - CNT_W'(res.freed);

  always_comb begin
    emit     = 1'b0;
    emit_rsp = '0;
    emit_rsp.active_count = 4'(count_next);
    case (cur.opcode)
      OP_ADD: begin
        emit = last_step;
        emit_rsp.last_result = 1'b1;
        if (cur.task_id == 16'd0) begin
          emit_rsp.result_kind = KIND_INVALID;
        end else if (placed || res.placed) begin
          emit_rsp.result_kind = KIND_ADDED;
          emit_rsp.slot_index  = placed ? placed_idx : 3'(step_idx);
          emit_rsp.run_task_id = cur.task_id;
        end else begin
          emit_rsp.result_kind = KIND_FULL;
        end
      end
      OP_DEL: begin
        emit = last_step;
        emit_rsp.last_result = 1'b1;
        emit_rsp.result_kind = KIND_DELETED;
        emit_rsp.slot_index  = cur.slot_number;
        emit_rsp.run_task_id = res.freed ? res.old_id : old_id;
      end
      OP_TICK: begin
        emit = res.run && (run_n < RUN_W'(MAX_RESULTS));
        emit_rsp.result_kind = KIND_RUN;
        emit_rsp.slot_index  = 3'(step_idx);
        emit_rsp.run_task_id = res.old_id;
        emit_rsp.last_result = !due_later || (run_n == RUN_W'(MAX_RESULTS - 1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step_idx  <= '0;
      placed    <= 1'b0;
      run_n     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= advance && emit;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            state    <= WALK;
            cur      <= req;
            step_idx <= '0;
            placed   <= 1'b0;
            old_id   <= 16'd0;
            run_n    <= '0;
          end
        end
        WALK: begin
          if (advance) begin
            count <= count_next;
            if (res.placed) begin
              placed     <= 1'b1;
              placed_idx <= 3'(step_idx);
            end
            if (res.freed && cur.opcode == OP_DEL) begin
              old_id <= res.old_id;
            end
            if (emit) begin
              out_q <= emit_rsp;
              if (cur.opcode == OP_TICK) begin
                run_n <= run_n + RUN_W'(1);
              end
            end
            if (last_step) begin
              state    <= IDLE;
              step_idx <= '0;
            end else begin
              step_idx <= step_idx + IDX_W'(1);
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign req_ready = (state == IDLE);
  assign rsp_valid = out_valid;
  assign rsp       = out_q;
endmodule

### rtl/tts_cell.sv
// One slot of the scheduler ring: holds a slot and passes it on when the ring turns.
// Depends on tts_pkg.
module tts_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  tts_pkg::slot_t d,
  output tts_pkg::slot_t q,
  output logic          due
);
  import tts_pkg::*;

  slot_t slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (shift) begin
      slot <= d;
    end
  end

  assign q   = slot;
  assign due = (slot.task_id != 16'd0) && (slot.countdown == 32'd0);
endmodule

### rtl/tts_step.sv
// Update logic for the slot at the head of the ring: add, delete or tick.
// Depends on tts_pkg.
module tts_step (
  input  tts_pkg::req_t  req,
  input  tts_pkg::slot_t head,
  input  logic           placed_before,
  input  logic           index_match,
  output tts_pkg::step_t res
);
  import tts_pkg::*;

  always_comb begin
    res          = '0;
    res.slot_new = head;
    case (req.opcode)
      OP_ADD: begin
        if (req.task_id != 16'd0 && head.task_id == 16'd0 && !placed_before) begin
          res.slot_new.task_id   = req.task_id;
          res.slot_new.countdown = req.first_delay;
          res.slot_new.period    = req.repeat_period;
          res.placed             = 1'b1;
        end
      end
      OP_DEL: begin
        if (index_match && head.task_id != 16'd0) begin
          res.slot_new = '0;
          res.freed    = 1'b1;
          res.old_id   = head.task_id;
        end
      end
      OP_TICK: begin
        if (head.task_id != 16'd0) begin
          if (head.countdown != 32'd0) begin
            res.slot_new.countdown = head.countdown - 32'd1;
          end else begin
            res.run    = 1'b1;
            res.old_id = head.task_id;
            if (head.period != 32'd0) begin
              res.slot_new.countdown = head.period - 32'd1;
            end else begin
              res.slot_new = '0;
              res.freed    = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end
endmodule
